// ===== rtl/core/ptp_pkg.sv =====
// -----------------------------------------------------------------------------
// Point-in-polygon test package
// Beat types and operation codes shared by the point-in-polygon test block.
// -----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEST   = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
   } req_type;

   typedef struct packed {
      logic       inside_res;
      logic [6:0] vertex_total;
      logic       polygon_usable;
      logic       append_dropped;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/point_in_polygon_test_top.sv =====
// -----------------------------------------------------------------------------
// Point-in-polygon test
// Holds one polygon in a vertex memory and answers even-odd ray casting
// queries, one edge per cycle through a short compare pipeline.
// -----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Beat
//  req_     in         req_valid/req_stall  ptp_pkg::req_type
//  rsp_     out        rsp_valid/rsp_stall  ptp_pkg::rsp_type
//
// Clear, append, unused operations and tests of fewer than three vertices
// pass from the idle state straight to the finish state, which registers the result.
// A test walks an n-vertex polygon through the single read port of the vertex
// memory, which delivers one vertex per cycle to the edge pipeline, then drains it.
// Synchronous reset empties the polygon; the memory itself is not cleared.
// One item is in work at a time; a result held by rsp_stall holds the next one.
// -----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_top #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire ptp_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      ptp_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic [32:0] n;
      n = v[32] ? (33'd0 - v) : v;
      return n[31:0];
   endfunction

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic signed [31:0] qx_ff, qx_in;
   logic signed [31:0] qy_ff, qy_in;
   logic               inside_ff, inside_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ptp_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [63:0]        vertex_mem [MAX_VERTICES];
   logic [63:0]        rd_data_ff;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [CW-1:0]      raddr_wide;

   logic               rd_valid_ff, rd_valid_in;
   logic               rd_first_ff, rd_first_in;
   logic signed [31:0] prev_x_ff, prev_y_ff;

   logic               b_valid_ff, b_cross_ff, b_dyneg_ff, b_lsgn_ff, b_rsgn_ff;
   logic [31:0]        b_ma_ff, b_mb_ff, b_mc_ff, b_md_ff;
   logic               c_valid_ff, c_cross_ff, c_dyneg_ff, c_lsgn_ff, c_rsgn_ff;
   logic [63:0]        c_lm_ff, c_rm_ff;

   logic signed [31:0] xi, yi;
   logic signed [32:0] da, db, dc, dd;
   logic               b_valid_in, b_cross_in;
   logic               lneg, rneg, l_lt_r, l_gt_r, toggle;
   logic [CW+6:0]      count_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Edge operands: vertex i from the memory, vertex j from the previous read.
   assign xi         = rd_data_ff[63:32];
   assign yi         = rd_data_ff[31:0];
   assign da         = {qx_ff[31], qx_ff} - {xi[31], xi};
   assign db         = {prev_y_ff[31], prev_y_ff} - {yi[31], yi};
   assign dc         = {prev_x_ff[31], prev_x_ff} - {xi[31], xi};
   assign dd         = {qy_ff[31], qy_ff} - {yi[31], yi};
   assign b_valid_in = rd_valid_ff && !rd_first_ff;
   assign b_cross_in = (yi > qy_ff) != (prev_y_ff > qy_ff);

   // Sign and magnitude compare of the two cross products.
   assign lneg   = c_lsgn_ff && (c_lm_ff != 64'd0);
   assign rneg   = c_rsgn_ff && (c_rm_ff != 64'd0);
   assign l_lt_r = (lneg != rneg) ? lneg : (lneg ? (c_lm_ff > c_rm_ff) : (c_lm_ff < c_rm_ff));
   assign l_gt_r = (lneg != rneg) ? rneg : (lneg ? (c_lm_ff < c_rm_ff) : (c_lm_ff > c_rm_ff));
   assign toggle = c_valid_ff && c_cross_ff && (c_dyneg_ff ? l_gt_r : l_lt_r);

   assign count_ext  = {7'd0, count_ff};
   assign raddr_wide = (issue_ff == '0) ? (count_ff - CW'(1)) : (issue_ff - CW'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      inside_in    = inside_ff ^ toggle;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_re       = 1'b0;
      mem_raddr    = raddr_wide[AW-1:0];
      rd_first_in  = (issue_ff == '0);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dropped_in = 1'b0;
               inside_in  = 1'b0;
               state_in   = ST_FINISH;
               unique case (req_data.operation)
                  ptp_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  ptp_pkg::OP_APPEND: begin
                     if (count_ff < CW'(MAX_VERTICES)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  ptp_pkg::OP_TEST: begin
                     qx_in    = req_data.coord_x;
                     qy_in    = req_data.coord_y;
                     issue_in = '0;
                     if (count_ff >= CW'(3)) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            mem_re   = 1'b1;
            issue_in = issue_ff + CW'(1);
            if (issue_ff == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !b_valid_ff && !c_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.inside_res      = inside_ff;
               rsp_data_in.vertex_total    = count_ext[6:0];
               rsp_data_in.polygon_usable  = (count_ff >= CW'(3));
               rsp_data_in.append_dropped  = dropped_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_valid_in = mem_re;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vertex_mem[mem_waddr] <= {req_data.coord_x, req_data.coord_y};
      end
      if (mem_re) begin
         rd_data_ff <= vertex_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         inside_ff    <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         inside_ff    <= inside_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rsp_data_ff <= rsp_data_in;
      rd_first_ff <= rd_first_in;
      if (rd_valid_ff) begin
         prev_x_ff <= xi;
         prev_y_ff <= yi;
      end
      b_cross_ff <= b_cross_in;
      b_dyneg_ff <= db[32];
      b_lsgn_ff  <= da[32] ^ db[32];
      b_rsgn_ff  <= dc[32] ^ dd[32];
      b_ma_ff    <= mag33(da);
      b_mb_ff    <= mag33(db);
      b_mc_ff    <= mag33(dc);
      b_md_ff    <= mag33(dd);
      c_cross_ff <= b_cross_ff;
      c_dyneg_ff <= b_dyneg_ff;
      c_lsgn_ff  <= b_lsgn_ff;
      c_rsgn_ff  <= b_rsgn_ff;
      c_lm_ff    <= 64'(b_ma_ff) * 64'(b_mb_ff);
      c_rm_ff    <= 64'(b_mc_ff) * 64'(b_md_ff);
   end

endmodule

`default_nettype wire

// ===== verif/point_in_polygon_test_top_tb.sv =====
// -----------------------------------------------------------------------------
// Point-in-polygon test testbench
// Drives clear, append, test and unused beats into the block and predicts every
// result beat with a crossing-number model of its own. Directed cases cover the
// empty, degenerate, extreme-coordinate and full-table polygons. Random rounds
// then build polygons at several coordinate scales and query points on and off
// their vertices, under phases of sender idling and receiver stalling.
// -----------------------------------------------------------------------------
module point_in_polygon_test_top_tb;

   localparam int TABLE_DEPTH = 64;
   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ptp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ptp_pkg::rsp_type rsp_data;

   logic signed [31:0] poly_x [TABLE_DEPTH];
   logic signed [31:0] poly_y [TABLE_DEPTH];
   int unsigned        poly_count = 0;
   ptp_pkg::rsp_type   expected_answers [$];
   int                 error_count = 0;
   int                 idle_cycles = 0;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   int                 beats_sent = 0;

   point_in_polygon_test_top #(.MAX_VERTICES(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic ray_crossings_odd(logic signed [31:0] qx, logic signed [31:0] qy);
      logic               odd;
      logic signed [67:0] dy;
      logic signed [67:0] lhs;
      logic signed [67:0] rhs;
      int unsigned        j;
      odd = 1'b0;
      if (poly_count < 3) begin
         return 1'b0;
      end
      j = poly_count - 1;
      for (int unsigned i = 0; i < poly_count; i++) begin
         if ((poly_y[i] > qy) != (poly_y[j] > qy)) begin
            dy = poly_y[j] - poly_y[i];
            lhs = (qx - poly_x[i]) * dy;
            rhs = (poly_x[j] - poly_x[i]) * (qy - poly_y[i]);
            if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) begin
               odd = ~odd;
            end
         end
         j = i;
      end
      return odd;
   endfunction

   function automatic void predict_answer(ptp_pkg::req_type beat);
      ptp_pkg::rsp_type answer;
      answer = '0;
      case (beat.operation)
         ptp_pkg::OP_CLEAR: begin
            poly_count = 0;
         end
         ptp_pkg::OP_APPEND: begin
            if (poly_count < TABLE_DEPTH) begin
               poly_x[poly_count] = beat.coord_x;
               poly_y[poly_count] = beat.coord_y;
               poly_count++;
            end else begin
               answer.append_dropped = 1'b1;
            end
         end
         ptp_pkg::OP_TEST: begin
            answer.inside_res = ray_crossings_odd(beat.coord_x, beat.coord_y);
         end
         default: begin
         end
      endcase
      answer.vertex_total = 7'(poly_count);
      answer.polygon_usable = (poly_count >= 3);
      expected_answers = {expected_answers, answer};
   endfunction

   function automatic void compare_field(string name, logic [6:0] exp_v, logic [6:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      ptp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            compare_field("inside_res", want.inside_res, rsp_data.inside_res);
            compare_field("vertex_total", want.vertex_total, rsp_data.vertex_total);
            compare_field("polygon_usable", want.polygon_usable, rsp_data.polygon_usable);
            compare_field("append_dropped", want.append_dropped, rsp_data.append_dropped);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_beat(logic [1:0] op, logic signed [31:0] cx, logic signed [31:0] cy);
      ptp_pkg::req_type beat;
      beat.operation = op;
      beat.coord_x = cx;
      beat.coord_y = cy;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      predict_answer(beat);
      beats_sent++;
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] rand_coord(int unsigned span_bits);
      logic signed [31:0] r;
      r = $urandom;
      return r >>> (32 - span_bits);
   endfunction

   task automatic run_polygon_round();
      int unsigned        span;
      int unsigned        corners;
      int unsigned        queries;
      int unsigned        pick;
      int unsigned        vtx;
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      case ($urandom_range(0, 3))
         0: span = 8;
         1: span = 16;
         2: span = 24;
         default: span = 32;
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         corners = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 4);
      end else if (pick < 3) begin
         corners = $urandom_range(0, 2);
      end else begin
         corners = $urandom_range(3, 10);
      end
      if ($urandom_range(0, 9) != 0) begin
         send_beat(ptp_pkg::OP_CLEAR, rand_coord(32), rand_coord(32));
      end
      for (int k = 0; k < corners; k++) begin
         send_beat(ptp_pkg::OP_APPEND, rand_coord(span), rand_coord(span));
      end
      queries = $urandom_range(2, 8);
      for (int k = 0; k < queries; k++) begin
         qx = rand_coord(span);
         qy = rand_coord(span);
         if (poly_count != 0) begin
            vtx = $urandom_range(0, poly_count - 1);
            case ($urandom_range(0, 7))
               0: begin
                  qx = poly_x[vtx];
                  qy = poly_y[vtx];
               end
               1, 2: begin
                  qy = poly_y[vtx];
               end
               3: begin
                  qx = poly_x[vtx];
               end
               default: begin
               end
            endcase
         end
         case ($urandom_range(0, 15))
            0: send_beat(OP_UNUSED, qx, qy);
            1: send_beat(ptp_pkg::OP_APPEND, qx, qy);
            default: send_beat(ptp_pkg::OP_TEST, qx, qy);
         endcase
      end
   endtask

   task automatic test_directed_cases();
      send_beat(ptp_pkg::OP_TEST, 0, 0);
      send_beat(OP_UNUSED, COORD_MIN, COORD_MAX);
      send_beat(ptp_pkg::OP_APPEND, COORD_MIN, COORD_MIN);
      send_beat(ptp_pkg::OP_TEST, 0, 0);
      send_beat(ptp_pkg::OP_APPEND, COORD_MAX, COORD_MIN);
      send_beat(ptp_pkg::OP_TEST, 0, 0);
      send_beat(ptp_pkg::OP_APPEND, COORD_MAX, COORD_MAX);
      send_beat(ptp_pkg::OP_TEST, 32'sd1000, -32'sd1000);
      send_beat(ptp_pkg::OP_APPEND, COORD_MIN, COORD_MAX);
      send_beat(ptp_pkg::OP_TEST, 0, 0);
      send_beat(ptp_pkg::OP_TEST, COORD_MIN, COORD_MIN);
      send_beat(ptp_pkg::OP_TEST, COORD_MAX, COORD_MAX);
      send_beat(ptp_pkg::OP_TEST, COORD_MIN, COORD_MAX);
      send_beat(ptp_pkg::OP_TEST, COORD_MAX, COORD_MIN);
      send_beat(ptp_pkg::OP_TEST, COORD_MIN, 0);
      send_beat(ptp_pkg::OP_TEST, COORD_MAX, 0);
      send_beat(ptp_pkg::OP_TEST, -1, -1);
      send_beat(OP_UNUSED, 0, 0);
      send_beat(ptp_pkg::OP_CLEAR, COORD_MAX, COORD_MIN);
      send_beat(ptp_pkg::OP_TEST, 0, 0);
      wait_for_answers();
   endtask

   task automatic test_table_full();
      send_beat(ptp_pkg::OP_CLEAR, 0, 0);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         send_beat(ptp_pkg::OP_APPEND, rand_coord(12), rand_coord(12));
      end
      send_beat(ptp_pkg::OP_APPEND, COORD_MAX, COORD_MAX);
      send_beat(ptp_pkg::OP_APPEND, COORD_MIN, COORD_MIN);
      send_beat(ptp_pkg::OP_TEST, 0, 0);
      send_beat(ptp_pkg::OP_TEST, rand_coord(12), poly_y[TABLE_DEPTH - 1]);
      send_beat(ptp_pkg::OP_TEST, rand_coord(12), rand_coord(12));
      wait_for_answers();
   endtask

   task automatic test_random_traffic(int send_pct, int stall_pct, int beat_count);
      int target;
      target = beats_sent + beat_count;
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
      while (beats_sent < target) begin
         run_polygon_round();
      end
      wait_for_answers();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_table_full();
      test_random_traffic(0, 0, 300);
      test_random_traffic(74, 0, 300);
      test_random_traffic(0, 74, 300);
      test_random_traffic(32, 32, 300);
      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
